### rtl/sorted_key_value_table_core_macros.svh
// ----------------------------------------------------------------------------
// Sorted key/value table assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_CORE_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset.
`define SKT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define SKT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define SKT_ASSERT(name, prop, msg)
`define SKT_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

### rtl/sktbl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Default sizes, cell control bundle and reduction tree depth helper.
// ----------------------------------------------------------------------------
package sktbl_pkg;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned ValueWidth = 32;

  // Fan-in of each node in the hit/value reduction tree.
  localparam int unsigned TreeRadix = 4;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic cmp_en;  // latch compare flags against the broadcast key
    logic ins_en;  // insert new key: shift up from ge point
    logic upd_en;  // overwrite value in the matching cell
    logic rem_en;  // remove: shift down from the matching cell
  } cell_ctrl_t;

  // Registered levels needed to fold n leaves with radix-4 nodes.
  function automatic int unsigned tree_levels(input int unsigned n);
    return ($clog2(n) + 1) / 2;
  endfunction

endpackage

### rtl/sktbl_cell.sv
// ----------------------------------------------------------------------------
// Sorted key/value table cell
// One table slot: key/value registers, compare flags, neighbor shift muxes.
// ----------------------------------------------------------------------------
module sktbl_cell #(
  parameter int unsigned KeyWidth   = sktbl_pkg::KeyWidth,
  parameter int unsigned ValueWidth = sktbl_pkg::ValueWidth
) (
  input  logic                   clk_i,
  input  sktbl_pkg::cell_ctrl_t  ctrl_i,
  input  logic                   occupied_i,
  input  logic                   tail_i,
  input  logic [KeyWidth-1:0]    key_i,
  input  logic [ValueWidth-1:0]  value_i,
  input  logic                   left_ge_i,
  input  logic [KeyWidth-1:0]    left_key_i,
  input  logic [ValueWidth-1:0]  left_value_i,
  input  logic [KeyWidth-1:0]    right_key_i,
  input  logic [ValueWidth-1:0]  right_value_i,
  output logic [KeyWidth-1:0]    key_o,
  output logic [ValueWidth-1:0]  value_o,
  output logic                   ge_o,
  output logic                   eq_o
);

  logic [KeyWidth-1:0]   key_q;
  logic [ValueWidth-1:0] value_q;
  logic                  ge_q;
  logic                  eq_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      ge_q <= occupied_i && (key_q >= key_i);
      eq_q <= occupied_i && (key_q == key_i);
    end
    if (ctrl_i.ins_en) begin
      if (left_ge_i) begin
        key_q   <= left_key_i;
        value_q <= left_value_i;
      end else if (ge_q || tail_i) begin
        // first slot at or above the new key, or first free slot
        key_q   <= key_i;
        value_q <= value_i;
      end
    end
    if (ctrl_i.upd_en && eq_q) begin
      value_q <= value_i;
    end
    if (ctrl_i.rem_en && ge_q) begin
      key_q   <= right_key_i;
      value_q <= right_value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign ge_o    = ge_q;
  assign eq_o    = eq_q;

endmodule

### rtl/sktbl_reduce.sv
// ----------------------------------------------------------------------------
// Sorted key/value table match reduction
// Registered radix-4 OR tree folding per-cell hit flags and masked values.
// ----------------------------------------------------------------------------
module sktbl_reduce #(
  parameter int unsigned Leaves = sktbl_pkg::Capacity,
  parameter int unsigned Width  = sktbl_pkg::ValueWidth
) (
  input  logic             clk_i,
  input  logic             hit_i   [Leaves],
  input  logic [Width-1:0] value_i [Leaves],
  output logic             hit_o,
  output logic [Width-1:0] value_o
);

  localparam int unsigned Levels = sktbl_pkg::tree_levels(Leaves);
  localparam int unsigned Radix  = sktbl_pkg::TreeRadix;

  // node j after fold level l+1 sits at [l][j]
  logic             hit_lvl [Levels][Leaves];
  logic [Width-1:0] val_lvl [Levels][Leaves];

  for (genvar l = 0; l < Levels; l++) begin : g_lvl
    // nodes feeding this level and nodes it produces
    localparam int unsigned InNodes  = (Leaves + Radix**l - 1) / Radix**l;
    localparam int unsigned OutNodes = (InNodes + Radix - 1) / Radix;

    for (genvar j = 0; j < OutNodes; j++) begin : g_node
      logic [Radix-1:0] kid_hit;
      logic [Width-1:0] kid_val [Radix];
      logic [Width-1:0] or_val;

      for (genvar m = 0; m < Radix; m++) begin : g_kid
        if (Radix * j + m >= InNodes) begin : g_pad
          assign kid_hit[m] = 1'b0;
          assign kid_val[m] = '0;
        end else if (l == 0) begin : g_leaf
          assign kid_hit[m] = hit_i[Radix*j+m];
          assign kid_val[m] = value_i[Radix*j+m];
        end else begin : g_inner
          assign kid_hit[m] = hit_lvl[l-1][Radix*j+m];
          assign kid_val[m] = val_lvl[l-1][Radix*j+m];
        end
      end

      always_comb begin
        or_val = '0;
        for (int unsigned m = 0; m < Radix; m++) begin
          or_val = or_val | kid_val[m];
        end
      end

      always_ff @(posedge clk_i) begin
        hit_lvl[l][j] <= |kid_hit;
        val_lvl[l][j] <= or_val;
      end
    end
  end

  assign hit_o   = hit_lvl[Levels-1][0];
  assign value_o = val_lvl[Levels-1][0];

endmodule

### rtl/sorted_key_value_table_core.sv
// ----------------------------------------------------------------------------
// Sorted key/value table core
// Bounded table of unique keys kept in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Each input transaction is one operation (insert/update, lookup, remove) and
// yields exactly one result transaction carrying found, read_value, status and
// the entry count after the operation. One operation is in flight at a time.
// A transaction accepted in idle passes through the compare, reduce and apply
// states: all cells compare against the key in parallel, then the L =
// ceil(log4(Capacity)) levels of the registered match reduction tree fold the
// per-cell match flags and values, then apply performs the shift/update and
// loads the result register, waiting while an earlier result is still untaken.
// The core is back in idle the cycle after the apply.
// The result sits in an output register, so the next transaction is accepted
// while the previous result still waits for out_ready_i; that next one then
// holds in its apply cycle until the waiting result is taken. Slot contents
// start undefined; slot i is live while i < entry count, so no clearing pass
// runs.
// ----------------------------------------------------------------------------
`include "sorted_key_value_table_core_macros.svh"

module sorted_key_value_table_core #(
  parameter int unsigned Capacity   = sktbl_pkg::Capacity,
  parameter int unsigned KeyWidth   = sktbl_pkg::KeyWidth,
  parameter int unsigned ValueWidth = sktbl_pkg::ValueWidth,
  localparam int unsigned CountWidth = $clog2(Capacity + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // operation channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            operation_i,
  input  logic [KeyWidth-1:0]   key_i,
  input  logic [ValueWidth-1:0] value_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [ValueWidth-1:0] read_value_o,
  output logic                  status_o,
  output logic [CountWidth-1:0] entry_count_o
);

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpLookup = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;

  localparam int unsigned Levels   = sktbl_pkg::tree_levels(Capacity);
  localparam int unsigned CntWidth = $clog2(Levels + 1);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StCmp    = 4'b0010,
    StReduce = 4'b0100,
    StApply  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CntWidth-1:0]   red_cnt_q, red_cnt_d;
  logic [CountWidth-1:0] count_q, count_d;

  // accepted transaction
  logic [1:0]            op_q;
  logic [KeyWidth-1:0]   key_q;
  logic [ValueWidth-1:0] value_q;

  // result register
  logic                  out_valid_q, out_valid_d;
  logic                  found_q;
  logic [ValueWidth-1:0] read_value_q;
  logic                  status_q;

  sktbl_pkg::cell_ctrl_t ctrl;
  logic                  apply_fire;
  logic                  do_ins, do_upd, do_rem, full;

  // cell row
  logic [KeyWidth-1:0]   cell_key   [Capacity];
  logic [ValueWidth-1:0] cell_value [Capacity];
  logic                  cell_ge    [Capacity];
  logic                  cell_eq    [Capacity];
  logic [ValueWidth-1:0] leaf_value [Capacity];

  logic                  tree_hit;
  logic [ValueWidth-1:0] tree_value;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                  left_ge;
    logic [KeyWidth-1:0]   left_key, right_key;
    logic [ValueWidth-1:0] left_value, right_value;

    if (i == 0) begin : g_head
      assign left_ge    = 1'b0;
      assign left_key   = '0;
      assign left_value = '0;
    end else begin : g_mid
      assign left_ge    = cell_ge[i-1];
      assign left_key   = cell_key[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_key   = '0;
      assign right_value = '0;
    end else begin : g_next
      assign right_key   = cell_key[i+1];
      assign right_value = cell_value[i+1];
    end

    sktbl_cell #(
      .KeyWidth   (KeyWidth),
      .ValueWidth (ValueWidth)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (CountWidth'(i) < count_q),
      .tail_i        (CountWidth'(i) == count_q),
      .key_i         (key_q),
      .value_i       (value_q),
      .left_ge_i     (left_ge),
      .left_key_i    (left_key),
      .left_value_i  (left_value),
      .right_key_i   (right_key),
      .right_value_i (right_value),
      .key_o         (cell_key[i]),
      .value_o       (cell_value[i]),
      .ge_o          (cell_ge[i]),
      .eq_o          (cell_eq[i])
    );

    // only the matching cell contributes its value to the fold
    assign leaf_value[i] = {ValueWidth{cell_eq[i]}} & cell_value[i];
  end

  sktbl_reduce #(
    .Leaves (Capacity),
    .Width  (ValueWidth)
  ) u_reduce (
    .clk_i   (clk_i),
    .hit_i   (cell_eq),
    .value_i (leaf_value),
    .hit_o   (tree_hit),
    .value_o (tree_value)
  );

  // apply-phase decisions
  assign full   = (count_q == CountWidth'(Capacity));
  assign do_ins = (op_q == OpInsert) && !tree_hit && !full;
  assign do_upd = (op_q == OpInsert) && tree_hit;
  assign do_rem = (op_q == OpRemove) && tree_hit;

  always_comb begin
    state_d     = state_q;
    red_cnt_d   = red_cnt_q;
    ctrl        = '0;
    apply_fire  = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        ctrl.cmp_en = 1'b1;
        red_cnt_d   = '0;
        state_d     = StReduce;
      end
      StReduce: begin
        red_cnt_d = red_cnt_q + 1'b1;
        if (red_cnt_q == CntWidth'(Levels - 1)) begin
          state_d = StApply;
        end
      end
      StApply: begin
        // wait for a free result slot
        if (!out_valid_q || out_ready_i) begin
          apply_fire  = 1'b1;
          ctrl.ins_en = do_ins;
          ctrl.upd_en = do_upd;
          ctrl.rem_en = do_rem;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (apply_fire && do_ins) begin
      count_d = count_q + 1'b1;
    end else if (apply_fire && do_rem) begin
      count_d = count_q - 1'b1;
    end
  end

  assign out_valid_d = apply_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      red_cnt_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      red_cnt_q   <= red_cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      op_q    <= operation_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (apply_fire) begin
      found_q      <= tree_hit;
      read_value_q <= (op_q == OpLookup) ? tree_value : '0;
      status_q     <= (op_q == OpInsert) && !tree_hit && full;
    end
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign read_value_o  = read_value_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SKT_ASSERT(a_count_bound, count_q <= CountWidth'(Capacity), "entry count above capacity")
  `SKT_ASSERT(a_full_status, !(out_valid_q && status_q) || full, "full status with free slots")
  `SKT_ASSERT_NEXT(a_ins_count, apply_fire && do_ins, count_q == $past(count_q) + 1'b1, "insert count")

endmodule
